// ----- sv/srts_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, codes and widths of the sparse row table store
// no dependencies

package srts_pkg;

   localparam int MAX_ROWS      = 4096;
   localparam int MAX_ENTRIES   = 8192;
   localparam int MAX_COLUMNS   = 1024;
   localparam int VALUE_ID_BITS = 16;

   // port field widths
   localparam int OP_W     = 2;
   localparam int ROW_W    = 12;
   localparam int COL_W    = 10;
   localparam int CCNT_W   = 11;
   localparam int STAT_W   = 3;
   localparam int ROWS_W   = $clog2(MAX_ROWS + 1);
   localparam int ENT_W    = $clog2(MAX_ENTRIES + 1);

   // memory shapes
   localparam int ENT_AW    = $clog2(MAX_ENTRIES);
   localparam int BND_DEPTH = MAX_ROWS + 1;
   localparam int BND_AW    = $clog2(BND_DEPTH);
   localparam int ENT_DW    = COL_W + VALUE_ID_BITS;

   typedef logic [OP_W-1:0]          op_type;
   typedef logic [STAT_W-1:0]        status_type;
   typedef logic [ROW_W-1:0]         row_type;
   typedef logic [COL_W-1:0]         col_type;
   typedef logic [CCNT_W-1:0]        ccnt_type;
   typedef logic [VALUE_ID_BITS-1:0] vid_type;
   typedef logic [ROWS_W-1:0]        rows_type;
   typedef logic [ENT_W-1:0]         ent_type;

   // operation codes
   localparam op_type OP_APPEND  = 2'd0;
   localparam op_type OP_END_ROW = 2'd1;
   localparam op_type OP_LOOKUP  = 2'd2;
   localparam op_type OP_CLEAR   = 2'd3;

   // status codes
   localparam status_type STAT_OK        = 3'd0;
   localparam status_type STAT_DROPPED   = 3'd1;
   localparam status_type STAT_FULL      = 3'd2;
   localparam status_type STAT_ORDER     = 3'd3;
   localparam status_type STAT_LOOKUP_OR = 3'd4;

endpackage

// ----- sv/srts_ram.sv -----
`timescale 1ns / 1ps
// generic simple dual port ram, one write and one registered read port
// no dependencies

module srts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/sparse_row_table_store.sv -----
`timescale 1ns / 1ps
// sparse_row_table_store: compressed sparse row table of cell value ids, on srts_pkg and srts_ram
// append, end row, clear and out-of-range lookup answer from decode, rsp beat registered behind it
// lookup: decode, upper and lower boundary reads, then a probe and a compare state per probe; a row
// holds at most 1024 ascending columns, so at most 11 probes (one entry ram read plus one compare each)
// busy stays high until the rsp cycle, the next req beat may be taken in it; no receiver stall
// sync active-high reset clears counts and control only; rams not cleared, boundary zero taken as 0

module sparse_row_table_store (
   input  logic                clock,
   input  logic                reset,
   // command beat
   input  logic                start,
   output logic                busy,
   input  srts_pkg::op_type    req_op,
   input  srts_pkg::row_type   req_row,
   input  srts_pkg::col_type   req_column,
   input  srts_pkg::vid_type   req_value_id,
   // result beat, one cycle strobe
   output logic                rsp_valid,
   output srts_pkg::status_type rsp_status,
   output logic                rsp_found,
   output srts_pkg::vid_type   rsp_cell_value,
   output srts_pkg::rows_type  rsp_rows_stored,
   output srts_pkg::ent_type   rsp_entries_stored,
   // column count register
   input  logic                csr_wr_en,
   input  srts_pkg::ccnt_type  csr_wr_data
);

   import srts_pkg::*;

   // sequencer codes
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_BND_HI = 3'd2;
   localparam logic [2:0] ST_BND_LO = 3'd3;
   localparam logic [2:0] ST_PROBE  = 3'd4;
   localparam logic [2:0] ST_CMP    = 3'd5;

   localparam ent_type  ENT_LIMIT = ENT_W'(MAX_ENTRIES);
   localparam rows_type ROW_LIMIT = ROWS_W'(MAX_ROWS);
   localparam ccnt_type COL_LIMIT = CCNT_W'(MAX_COLUMNS);

   // control state
   logic [2:0] state_ff, state_in;
   rows_type   rows_ff, rows_in;
   ent_type    entries_ff, entries_in;
   ccnt_type   last_col_ff, last_col_in;
   ccnt_type   col_count_ff, col_count_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // latched command and search registers (payload, no reset)
   op_type     op_ff, op_in;
   row_type    row_ff, row_in;
   col_type    col_ff, col_in;
   vid_type    vid_ff, vid_in;
   ent_type    lo_ff, lo_in;
   ent_type    hi_ff, hi_in;
   status_type status_ff, status_in;
   logic       found_ff, found_in;
   vid_type    cell_ff, cell_in;

   // ram ports
   logic                bnd_wr_en;
   logic [BND_AW-1:0]   bnd_wr_addr;
   logic [BND_AW-1:0]   bnd_rd_addr;
   logic [ENT_W-1:0]    bnd_rd_data;
   logic                ent_wr_en;
   logic [ENT_AW-1:0]   ent_rd_addr;
   logic [ENT_DW-1:0]   ent_rd_data;

   // shared search datapath
   ent_type    mid_full;
   ccnt_type   eff_cols;
   col_type    probe_col;
   vid_type    probe_vid;
   ent_type    bnd_clamped;

   // row boundary per completed row, boundary zero is never written
   srts_ram #(.WIDTH(ENT_W), .DEPTH(BND_DEPTH)) u_bnd_ram (
      .clock   (clock),
      .wr_en   (bnd_wr_en),
      .wr_addr (bnd_wr_addr),
      .wr_data (entries_ff),
      .rd_addr (bnd_rd_addr),
      .rd_data (bnd_rd_data)
   );

   // column and value id per entry, packed as {column, value id}
   srts_ram #(.WIDTH(ENT_DW), .DEPTH(MAX_ENTRIES)) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (entries_ff[ENT_AW-1:0]),
      .wr_data ({col_ff, vid_ff}),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   // schema width saturates at the column limit
   assign eff_cols    = (col_count_ff > COL_LIMIT) ? COL_LIMIT : col_count_ff;
   // midpoint of the open search window, always below hi so it fits the ram address
   assign mid_full    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign probe_col   = ent_rd_data[ENT_DW-1:VALUE_ID_BITS];
   assign probe_vid   = ent_rd_data[VALUE_ID_BITS-1:0];
   assign bnd_clamped = (bnd_rd_data > entries_ff) ? entries_ff : bnd_rd_data;

   assign ent_rd_addr = mid_full[ENT_AW-1:0];
   // upper boundary is read first, then the lower one
   assign bnd_rd_addr = (state_ff == ST_DECODE) ? (BND_AW'(row_ff) + BND_AW'(1))
                                                : BND_AW'(row_ff);
   assign bnd_wr_addr = BND_AW'(rows_ff) + BND_AW'(1);

   always_comb begin
      state_in     = state_ff;
      rows_in      = rows_ff;
      entries_in   = entries_ff;
      last_col_in  = last_col_ff;
      col_count_in = csr_wr_en ? csr_wr_data : col_count_ff;
      rsp_valid_in = 1'b0;
      op_in        = op_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      vid_in       = vid_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      cell_in      = cell_ff;
      bnd_wr_en    = 1'b0;
      ent_wr_en    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in     = req_op;
               row_in    = req_row;
               col_in    = req_column;
               vid_in    = req_value_id;
               status_in = STAT_OK;
               found_in  = 1'b0;
               cell_in   = '0;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (op_ff)
               OP_APPEND: begin
                  if (CCNT_W'(col_ff) >= eff_cols) begin
                     status_in = STAT_DROPPED;
                  end else if (CCNT_W'(col_ff) < last_col_ff) begin
                     status_in = STAT_ORDER;
                  end else if (entries_ff >= ENT_LIMIT) begin
                     status_in = STAT_FULL;
                  end else begin
                     ent_wr_en   = 1'b1;
                     entries_in  = entries_ff + ENT_W'(1);
                     last_col_in = CCNT_W'(col_ff) + CCNT_W'(1);
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
               OP_END_ROW: begin
                  if (rows_ff >= ROW_LIMIT) begin
                     status_in = STAT_FULL;
                  end else begin
                     bnd_wr_en   = 1'b1;
                     rows_in     = rows_ff + ROWS_W'(1);
                     last_col_in = '0;
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
               OP_LOOKUP: begin
                  if (ROWS_W'(row_ff) >= rows_ff || CCNT_W'(col_ff) >= eff_cols) begin
                     status_in    = STAT_LOOKUP_OR;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     state_in = ST_BND_HI;
                  end
               end
               default: begin
                  // clear table: boundary zero is never written, row 0 takes its lower bound as 0
                  rows_in      = '0;
                  entries_in   = '0;
                  last_col_in  = '0;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            endcase
         end
         ST_BND_HI: begin
            hi_in    = bnd_clamped;
            state_in = ST_BND_LO;
         end
         ST_BND_LO: begin
            lo_in    = (row_ff == '0) ? '0 : bnd_rd_data;
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            // read at the midpoint goes out here, compare next cycle
            if (lo_ff < hi_ff) begin
               state_in = ST_CMP;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CMP: begin
            if (probe_col == col_ff) begin
               found_in     = 1'b1;
               cell_in      = probe_vid;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               if (probe_col < col_ff) begin
                  lo_in = mid_full + ENT_W'(1);
               end else begin
                  hi_in = mid_full;
               end
               state_in = ST_PROBE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= '0;
         entries_ff   <= '0;
         last_col_ff  <= '0;
         col_count_ff <= COL_LIMIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         entries_ff   <= entries_in;
         last_col_ff  <= last_col_in;
         col_count_ff <= col_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      vid_ff    <= vid_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      cell_ff   <= cell_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_found          = found_ff;
   assign rsp_cell_value     = cell_ff;
   // counts only move in the decode cycle, so they are stable through the rsp beat
   assign rsp_rows_stored    = rows_ff;
   assign rsp_entries_stored = entries_ff;

endmodule

// ----- sv/srts_checker.sv -----
`timescale 1ns / 1ps
// port level checks for the sparse row table store, bound to the top level
// depends on srts_pkg and sparse_row_table_store

module srts_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic                 rsp_valid,
   input  srts_pkg::status_type rsp_status,
   input  logic                 rsp_found,
   input  srts_pkg::vid_type    rsp_cell_value
);

   import srts_pkg::*;

   // an accepted beat keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   // the rsp beat comes with the block idle again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("rsp beat while busy");

   // one strobe per item, never two in a row
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp strobe longer than one cycle");

   // a hit is always an ok lookup
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == STAT_OK))
      else $error("found with non-ok status");

   // a miss carries a zero value
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_cell_value == '0))
      else $error("miss with nonzero cell value");

endmodule

bind sparse_row_table_store srts_checker u_srts_checker (.*);

// ----- tb/tb_sparse_row_table_store.sv -----
`timescale 1ns / 1ps
// self-checking bench for sparse_row_table_store: directed and random command beats,
// every result beat checked against an in-bench model of the sparse row table
// depends on srts_pkg and the sparse_row_table_store rtl

module tb_sparse_row_table_store;
   import srts_pkg::*;

   localparam int CYCLE_LIMIT  = 3_000_000;
   // leave headroom for the longest lookup before the final check
   localparam int DRAIN_CYCLES = 40;

   // one command beat waiting to be driven
   typedef struct {
      op_type  op;
      row_type row;
      col_type col;
      vid_type vid;
      bit      drain_first;   // hold the sender until every result is back
   } table_cmd_type;

   // the result beat the table should give for one command
   typedef struct {
      status_type status;
      logic       found;
      vid_type    cell_value;
      rows_type   rows;
      ent_type    ents;
   } table_answer_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   op_type     req_op       = OP_LOOKUP;
   row_type    req_row      = '0;
   col_type    req_column   = '0;
   vid_type    req_value_id = '0;
   logic       rsp_valid;
   status_type rsp_status;
   logic       rsp_found;
   vid_type    rsp_cell_value;
   rows_type   rsp_rows_stored;
   ent_type    rsp_entries_stored;
   logic       csr_wr_en   = 1'b0;
   ccnt_type   csr_wr_data = '0;

   sparse_row_table_store dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_row            (req_row),
      .req_column         (req_column),
      .req_value_id       (req_value_id),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_found          (rsp_found),
      .rsp_cell_value     (rsp_cell_value),
      .rsp_rows_stored    (rsp_rows_stored),
      .rsp_entries_stored (rsp_entries_stored),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // command beats still to drive, and results still owed by the table
   table_cmd_type    table_cmds[$];
   table_answer_type table_answers[$];

   // beat counters, both updated with nonblocking writes so either side reads
   // a stable value at the clock edge
   int beats_sent = 0;
   int beats_seen = 0;

   int sender_idle_pct = 0;
   int fail_count      = 0;
   int cycle_count     = 0;
   int schema_changes  = 0;

   // result tallies for the closing summary
   int hit_count   = 0;
   int oor_count   = 0;
   int drop_count  = 0;
   int order_count = 0;
   int full_count  = 0;

   // ---------------------------------------------------------------
   // table model: boundaries, column and value stores, counters
   // ---------------------------------------------------------------
   int      bound_mem [0:MAX_ROWS];
   int      col_mem   [0:MAX_ENTRIES-1];
   vid_type vid_mem   [0:MAX_ENTRIES-1];
   int      rows_done   = 0;
   int      cells_done  = 0;
   int      col_floor   = 0;   // lowest column the open row still accepts
   int      schema_cols = 1024;

   initial bound_mem[0] = 0;

   // advance the model by one command and produce the result it owes
   task automatic apply_table_cmd(input op_type op, input row_type row, input col_type col,
                                  input vid_type vid, output table_answer_type ans);
      int eff;
      int lo;
      int hi;
      int mid;
      // schema count saturates at the widest table
      eff = (schema_cols > MAX_COLUMNS) ? MAX_COLUMNS : schema_cols;
      ans.status     = STAT_OK;
      ans.found      = 1'b0;
      ans.cell_value = '0;
      case (op)
         OP_APPEND: begin
            // range first, then order, then capacity
            if (int'(col) >= eff) begin
               ans.status = STAT_DROPPED;
            end else if (int'(col) < col_floor) begin
               ans.status = STAT_ORDER;
            end else if (cells_done >= MAX_ENTRIES) begin
               ans.status = STAT_FULL;
            end else begin
               col_mem[cells_done] = col;
               vid_mem[cells_done] = vid;
               cells_done++;
               col_floor = int'(col) + 1;
            end
         end
         OP_END_ROW: begin
            // a full row store leaves the row open with its entries
            if (rows_done >= MAX_ROWS) begin
               ans.status = STAT_FULL;
            end else begin
               bound_mem[rows_done + 1] = cells_done;
               rows_done++;
               col_floor = 0;
            end
         end
         OP_LOOKUP: begin
            if (int'(row) >= rows_done || int'(col) >= eff) begin
               ans.status = STAT_LOOKUP_OR;
            end else begin
               lo = bound_mem[row];
               hi = bound_mem[int'(row) + 1];
               if (hi > cells_done) hi = cells_done;
               // binary search over the row's ascending columns
               while (lo < hi && !ans.found) begin
                  mid = lo + (hi - lo) / 2;
                  if (col_mem[mid] == int'(col)) begin
                     ans.found      = 1'b1;
                     ans.cell_value = vid_mem[mid];
                  end else if (col_mem[mid] < int'(col)) begin
                     lo = mid + 1;
                  end else begin
                     hi = mid;
                  end
               end
            end
         end
         default: begin
            rows_done    = 0;
            cells_done   = 0;
            col_floor    = 0;
            bound_mem[0] = 0;
         end
      endcase
      ans.rows = rows_type'(rows_done);
      ans.ents = ent_type'(cells_done);
   endtask

   // ---------------------------------------------------------------
   // driver: takes a beat when start meets busy low, then offers the next
   // ---------------------------------------------------------------
   always @(posedge clock) begin : drive_proc
      logic             fire;
      logic             offer;
      table_cmd_type    nxt;
      table_answer_type ans;
      if (reset) begin
         start <= 1'b0;
      end else begin
         fire = start && !busy;
         if (fire) begin
            // predict from what was on the ports when the beat was taken
            apply_table_cmd(req_op, req_row, req_column, req_value_id, ans);
            table_answers.push_back(ans);
            beats_sent <= beats_sent + 1;
         end
         if (!start || fire) begin
            offer = table_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct;
            // pause point: nothing new until the table has answered everything
            if (offer && table_cmds[0].drain_first && (fire || beats_sent != beats_seen))
               offer = 1'b0;
            if (offer) begin
               nxt = table_cmds.pop_front();
               req_op       <= nxt.op;
               req_row      <= nxt.row;
               req_column   <= nxt.col;
               req_value_id <= nxt.vid;
            end
            start <= offer;
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: every strobed result beat is matched to the oldest prediction
   // ---------------------------------------------------------------
   task automatic check_field(input string field_name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", field_name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch_proc
      table_answer_type want;
      if (!reset && rsp_valid === 1'b1) begin
         beats_seen <= beats_seen + 1;
         if (table_answers.size() == 0) begin
            $error("result beat with no command outstanding");
            fail_count++;
         end else begin
            want = table_answers.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("found", want.found, rsp_found);
            check_field("cell_value", want.cell_value, rsp_cell_value);
            check_field("rows_stored", want.rows, rsp_rows_stored);
            check_field("entries_stored", want.ents, rsp_entries_stored);
            if (want.found) hit_count++;
            case (want.status)
               STAT_LOOKUP_OR: oor_count++;
               STAT_DROPPED:   drop_count++;
               STAT_ORDER:     order_count++;
               STAT_FULL:      full_count++;
               default: ;
            endcase
         end
      end else if (!reset && rsp_valid !== 1'b0) begin
         $error("rsp_valid unknown");
         fail_count++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, table_answers.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // stimulus generation
   // ---------------------------------------------------------------
   // loose shadow of the table, used only to aim lookups at stored cells
   int gen_rows = 0;
   int known_rows[$];
   int known_cols[$];

   task automatic push_cmd(input op_type op, input int row, input int col, input int vid);
      table_cmd_type c;
      c.op          = op;
      c.row         = row_type'(row);
      c.col         = col_type'(col);
      c.vid         = vid_type'(vid);
      c.drain_first = ($urandom_range(0, 199) == 0);
      table_cmds.push_back(c);
      if (op == OP_CLEAR) begin
         gen_rows = 0;
         known_rows.delete();
         known_cols.delete();
      end else if (op == OP_END_ROW && gen_rows < MAX_ROWS) begin
         gen_rows++;
      end
   endtask

   // wait until no beat is queued, in flight or owed
   task automatic wait_table_idle();
      @(negedge clock);
      while (table_cmds.size() != 0 || start || beats_sent != beats_seen)
         @(negedge clock);
   endtask

   // column count write, only ever done with the table idle
   task automatic program_schema(input int cols);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ccnt_type'(cols);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      schema_cols = cols;
      schema_changes++;
      @(negedge clock);
   endtask

   // hand-picked corners with the reset schema of 1024 columns
   task automatic queue_directed();
      push_cmd(OP_LOOKUP, 0, 0, 0);            // empty table, out of range
      push_cmd(OP_APPEND, 0, 0, 0);            // lowest column, zero id
      push_cmd(OP_APPEND, 0, 1023, 16'hffff);  // top column, top id
      push_cmd(OP_APPEND, 0, 1023, 16'h1234);  // repeat column, out of order
      push_cmd(OP_APPEND, 0, 5, 16'h4321);     // lower column, out of order
      push_cmd(OP_END_ROW, 4095, 1023, 16'hffff);
      push_cmd(OP_LOOKUP, 0, 0, 16'hffff);     // hit with zero id
      push_cmd(OP_LOOKUP, 0, 1023, 0);         // hit at top column
      table_cmds[table_cmds.size() - 1].drain_first = 1'b1;
      push_cmd(OP_LOOKUP, 0, 512, 0);          // blank cell
      push_cmd(OP_LOOKUP, 1, 0, 0);            // row still open
      push_cmd(OP_LOOKUP, 4095, 1023, 0);      // row far beyond the table
      push_cmd(OP_END_ROW, 0, 0, 0);           // empty row
      push_cmd(OP_LOOKUP, 1, 7, 0);            // lookup in empty row
      push_cmd(OP_APPEND, 0, 300, 16'ha5a5);
      push_cmd(OP_APPEND, 0, 301, 16'h5a5a);
      push_cmd(OP_END_ROW, 0, 0, 0);
      push_cmd(OP_LOOKUP, 2, 301, 0);
      push_cmd(OP_LOOKUP, 2, 300, 0);
      push_cmd(OP_LOOKUP, 2, 299, 0);
      push_cmd(OP_CLEAR, 4095, 1023, 16'hffff);
      push_cmd(OP_LOOKUP, 0, 0, 0);            // cleared, out of range again
      push_cmd(OP_END_ROW, 0, 0, 0);
      push_cmd(OP_LOOKUP, 0, 0, 0);
   endtask

   // lowest and highest column against whatever schema is in force
   task automatic queue_schema_edges();
      push_cmd(OP_CLEAR, 0, 0, 0);
      push_cmd(OP_APPEND, 0, 0, $urandom_range(0, 65535));
      push_cmd(OP_APPEND, 0, 1023, $urandom_range(0, 65535));
      push_cmd(OP_END_ROW, 0, 0, 0);
      push_cmd(OP_LOOKUP, 0, 1023, 0);
      push_cmd(OP_LOOKUP, 0, 0, 0);
   endtask

   // mostly well formed rows and lookups, with broken rows and raw noise mixed in
   task automatic queue_random(input int count);
      int made;
      int pick;
      int n;
      int k;
      int prev;
      int top;
      int c;
      int eff;
      made = 0;
      eff  = (schema_cols > MAX_COLUMNS) ? MAX_COLUMNS : schema_cols;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            // build one row of ascending columns
            n    = $urandom_range(0, 7);
            k    = 0;
            prev = -1;
            while (k < n && prev + 1 < eff) begin
               top = prev + 1 + $urandom_range(0, eff / 4);
               if (top > eff - 1) top = eff - 1;
               c = $urandom_range(prev + 1, top);
               push_cmd(OP_APPEND, $urandom_range(0, 4095), c, $urandom_range(0, 65535));
               known_rows.push_back(gen_rows);
               known_cols.push_back(c);
               prev = c;
               k++;
            end
            made += k;
            // sometimes break the row with a column that is not above the last
            if (eff == 0 || $urandom_range(0, 9) == 0) begin
               c = (prev >= 0) ? $urandom_range(0, prev) : $urandom_range(0, 1023);
               push_cmd(OP_APPEND, 0, c, $urandom_range(0, 65535));
               made++;
            end
            push_cmd(OP_END_ROW, $urandom_range(0, 4095), $urandom_range(0, 1023),
                     $urandom_range(0, 65535));
            made++;
         end else if (pick < 85) begin
            if (known_rows.size() > 0 && $urandom_range(0, 1) == 1) begin
               k = $urandom_range(0, known_rows.size() - 1);
               push_cmd(OP_LOOKUP, known_rows[k], known_cols[k], $urandom_range(0, 65535));
            end else if ($urandom_range(0, 1) == 1) begin
               push_cmd(OP_LOOKUP, $urandom_range(0, gen_rows + 1), $urandom_range(0, 1023),
                        $urandom_range(0, 65535));
            end else begin
               push_cmd(OP_LOOKUP, $urandom_range(0, 4095), $urandom_range(0, 1023),
                        $urandom_range(0, 65535));
            end
            made++;
         end else begin
            // noise: any op, any fields, clears kept rare
            c = $urandom_range(0, 3);
            if (c == OP_CLEAR && $urandom_range(0, 3) != 0) c = OP_APPEND;
            push_cmd(op_type'(c), $urandom_range(0, 4095), $urandom_range(0, 1023),
                     $urandom_range(0, 65535));
            made++;
         end
      end
   endtask

   // new schema and sender idling, only once the table is quiet
   task automatic start_phase(input int cols, input int idle_pct);
      wait_table_idle();
      program_schema(cols);
      sender_idle_pct = idle_pct;
      queue_schema_edges();
   endtask

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------
   initial begin : stimulus_proc
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // light sender idling
      sender_idle_pct = 12;
      program_schema(1024);
      queue_directed();
      start_phase(1024, 12);
      queue_random(180);
      start_phase(1, 12);                          // single column schema
      queue_random(50);

      // heavy sender idling
      start_phase($urandom_range(2, 1023), 75);
      queue_random(180);
      start_phase(2047, 75);                       // saturates to the widest table
      queue_random(140);

      // back to back
      start_phase(0, 0);                           // every column dropped
      queue_random(30);
      start_phase(1024, 0);
      queue_random(90);

      wait_table_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (table_answers.size() != 0) begin
         $error("%0d results never arrived", table_answers.size());
         fail_count++;
      end
      $display("%0d result beats over %0d column counts, three sender idle levels",
               beats_seen, schema_changes);
      $display("lookup hits %0d, out of range %0d, dropped %0d, out of order %0d, full %0d",
               hit_count, oor_count, drop_count, order_count, full_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
